>>> rtl/core/hwt_pkg.sv
// hwt_pkg: shared constants and types of the hashed timing wheel
// used by the channel interfaces, the wheel core and its checker; no dependencies

package hwt_pkg;

	localparam int unsigned WHEEL_CELLS_DEF    = 64;
	localparam int unsigned SLOTS_PER_CELL_DEF = 8;
	localparam int unsigned DELAY_BITS_DEF     = 24;

	localparam int unsigned CFG_W      = 7;
	localparam int unsigned HANDLE_W   = 16;
	localparam int unsigned CELL_OUT_W = 6;

	localparam logic [CFG_W-1:0] WHEEL_SIZE_RST = 7'd64;

	typedef enum logic [1:0] {
		STAT_ACCEPTED = 2'd0,
		STAT_REJECTED = 2'd1,
		STAT_EXPIRED  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_ROT,
		S_DIV_CELL,
		S_DIV_TICK,
		S_READ,
		S_CHECK,
		S_FLUSH
	} state_t;

endpackage

>>> rtl/core/hwt_ifs.sv
// hwt_ifs: valid/ready channel interfaces of the hashed timing wheel
// request, response and configuration words; depends on hwt_pkg

interface hwt_req_if import hwt_pkg::*; #(
	parameter int unsigned DELAY_BITS = DELAY_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [DELAY_BITS-1:0] delay;
	logic [HANDLE_W-1:0]   task_id;

	modport source (output valid, kind, delay, task_id, input ready);
	modport sink (input valid, kind, delay, task_id, output ready);
endinterface

interface hwt_rsp_if import hwt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [HANDLE_W-1:0]   task_handle;
	logic [CELL_OUT_W-1:0] cell_index;
	logic                  last;

	modport source (output valid, status, task_handle, cell_index, last, input ready);
	modport sink (input valid, status, task_handle, cell_index, last, output ready);
endinterface

interface hwt_cfg_if import hwt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/hwt_ram.sv
// hwt_ram: generic single-clock ram, one write and one read port, registered read
// no dependencies

module hwt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/hwt_div.sv
// hwt_div: radix-2 restoring divider, one quotient bit per cycle
// gives quotient and remainder when done rises after start; no dependencies

module hwt_div #(
	parameter int unsigned DW = 24,
	parameter int unsigned SW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [SW-1:0] rem
);

	localparam int unsigned CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] quot_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [SW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quot_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				cnt_q  <= CW'(DW);
				done_q <= 1'b0;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[DW-2:0], fits};
			rem_q  <= fits ? SW'(trial - {1'b0, dvs_q}) : trial[SW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

>>> rtl/core/hashed_timing_wheel.sv
// hashed_timing_wheel: task timer wheel, all slots kept in one ram, read-modify-write
// add: two serial divisions (rotations, then cell), then a read and check per slot probed
// tick: one serial division for the next cell, then a read and check of every slot in it,
// one word at a time; expired words can stall the scan while they wait on rsp.ready
// after reset a clearing pass over all WHEEL_CELLS*SLOTS_PER_CELL slots holds req.ready low
// depends on hwt_pkg, hwt_ifs, hwt_ram, hwt_div

module hashed_timing_wheel import hwt_pkg::*; #(
	parameter int unsigned WHEEL_CELLS    = WHEEL_CELLS_DEF,
	parameter int unsigned SLOTS_PER_CELL = SLOTS_PER_CELL_DEF,
	parameter int unsigned DELAY_BITS     = DELAY_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hwt_req_if.sink   req,
	hwt_rsp_if.source rsp,
	hwt_cfg_if.sink   cfg
);

	localparam int unsigned CELL_W = $clog2(WHEEL_CELLS);
	localparam int unsigned SW     = CELL_W + 1;
	localparam int unsigned TOTAL  = WHEEL_CELLS * SLOTS_PER_CELL;
	localparam int unsigned AW     = $clog2(TOTAL);
	localparam int unsigned SLW    = $clog2(SLOTS_PER_CELL + 1);
	localparam int unsigned DW     = (DELAY_BITS > SW) ? DELAY_BITS : SW;
	localparam int unsigned RW     = 1 + DELAY_BITS + HANDLE_W;
	localparam int unsigned CMP_W  = (CFG_W > SW) ? CFG_W : SW;

	state_t state_q, state_nx;

	logic [CFG_W-1:0]      wheel_size_q;
	logic [CELL_W-1:0]     cur_q;
	logic [AW-1:0]         clr_q;
	logic                  op_add_q;
	logic [SLW-1:0]        slot_q;
	logic [CELL_W-1:0]     cell_q;
	logic [DELAY_BITS-1:0] rot_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic                  pend_valid_q;
	status_t               pend_status_q;
	logic [HANDLE_W-1:0]   pend_handle_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [CELL_OUT_W-1:0] out_cell_q;
	logic                  out_last_q;

	logic [CMP_W-1:0]      ws_ext;
	logic [SW-1:0]         size;
	logic                  req_acc;
	logic                  out_free;
	logic [DELAY_BITS-1:0] delay_m1;

	logic                  div_start;
	logic [DW-1:0]         div_dividend;
	logic                  div_done;
	logic [DW-1:0]         div_quot;
	logic [SW-1:0]         div_rem;

	logic                  ram_we;
	logic                  ram_re;
	logic [AW-1:0]         ram_addr;
	logic [AW-1:0]         slot_addr;
	logic [RW-1:0]         ram_wdata;
	logic [RW-1:0]         ram_rdata;
	logic                  rd_valid;
	logic [DELAY_BITS-1:0] rd_rot;
	logic [HANDLE_W-1:0]   rd_handle;

	logic [SLW-1:0]        slot_nx;
	logic                  slot_end;
	logic                  slot_adv;
	logic                  rot_load;
	logic                  cell_load;
	logic                  cur_load;
	logic                  pend_load;
	logic                  pend_clear;
	status_t               pend_status_nx;
	logic [HANDLE_W-1:0]   pend_handle_nx;
	logic                  out_push;
	logic                  out_last_nx;
	logic                  expire_stall;

	// effective wheel size
	assign ws_ext = CMP_W'(wheel_size_q);
	assign size   = (ws_ext == '0) ? SW'(1) :
		(ws_ext > CMP_W'(WHEEL_CELLS)) ? SW'(WHEEL_CELLS) : SW'(ws_ext);

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;
	assign delay_m1  = (req.delay == '0) ? '0 : req.delay - DELAY_BITS'(1);

	assign slot_addr = AW'(cell_q) * AW'(SLOTS_PER_CELL) + AW'(slot_q);
	assign slot_nx   = slot_q + SLW'(1);
	assign slot_end  = (slot_nx == SLW'(SLOTS_PER_CELL));

	assign rd_valid  = ram_rdata[RW-1];
	assign rd_rot    = ram_rdata[DELAY_BITS+HANDLE_W-1:HANDLE_W];
	assign rd_handle = ram_rdata[HANDLE_W-1:0];

	assign expire_stall = rd_valid && (rd_rot == '0) && pend_valid_q && !out_free;

	hwt_div #(
		.DW (DW),
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (size),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	hwt_ram #(
		.WIDTH (RW),
		.DEPTH (TOTAL)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(TOTAL - 1)) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_acc) begin
					state_nx = req.kind ? S_DIV_ROT : S_DIV_TICK;
				end
			end
			S_DIV_ROT: begin
				if (div_done) begin
					state_nx = S_DIV_CELL;
				end
			end
			S_DIV_CELL, S_DIV_TICK: begin
				if (div_done) begin
					state_nx = S_READ;
				end
			end
			S_READ: begin
				state_nx = S_CHECK;
			end
			S_CHECK: begin
				if (op_add_q) begin
					if (!rd_valid || slot_end) begin
						state_nx = S_FLUSH;
					end else begin
						state_nx = S_READ;
					end
				end else if (!expire_stall) begin
					state_nx = slot_end ? S_FLUSH : S_READ;
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_CLEAR;
			end
		endcase
	end

	// control outputs
	always_comb begin
		div_start      = 1'b0;
		div_dividend   = DW'(cur_q) + DW'(1);
		ram_we         = 1'b0;
		ram_re         = 1'b0;
		ram_addr       = slot_addr;
		ram_wdata      = '0;
		slot_adv       = 1'b0;
		rot_load       = 1'b0;
		cell_load      = 1'b0;
		cur_load       = 1'b0;
		pend_load      = 1'b0;
		pend_clear     = 1'b0;
		pend_status_nx = STAT_EXPIRED;
		pend_handle_nx = rd_handle;
		out_push       = 1'b0;
		out_last_nx    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			S_IDLE: begin
				div_start = req_acc;
				if (req.kind) begin
					div_dividend = DW'(delay_m1);
				end
			end
			S_DIV_ROT: begin
				div_start    = div_done;
				div_dividend = DW'(cur_q) + DW'(div_rem) + DW'(1);
				rot_load     = div_done;
			end
			S_DIV_CELL: begin
				cell_load = div_done;
			end
			S_DIV_TICK: begin
				cell_load = div_done;
				cur_load  = div_done;
			end
			S_READ: begin
				ram_re = 1'b1;
			end
			S_CHECK: begin
				if (op_add_q) begin
					pend_handle_nx = handle_q;
					if (!rd_valid) begin
						ram_we         = 1'b1;
						ram_wdata      = {1'b1, rot_q, handle_q};
						pend_load      = 1'b1;
						pend_status_nx = STAT_ACCEPTED;
					end else begin
						slot_adv = 1'b1;
						if (slot_end) begin
							pend_load      = 1'b1;
							pend_status_nx = STAT_REJECTED;
						end
					end
				end else if (!expire_stall) begin
					slot_adv = 1'b1;
					if (rd_valid && rd_rot != '0) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, rd_rot - DELAY_BITS'(1), rd_handle};
					end else if (rd_valid) begin
						// expired: free the slot, earlier expiry goes out as not last
						ram_we    = 1'b1;
						ram_wdata = '0;
						pend_load = 1'b1;
						out_push  = pend_valid_q;
					end
				end
			end
			S_FLUSH: begin
				if (pend_valid_q && out_free) begin
					out_push    = 1'b1;
					out_last_nx = 1'b1;
					pend_clear  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			wheel_size_q <= WHEEL_SIZE_RST;
			cur_q        <= '0;
			op_add_q     <= 1'b0;
			slot_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg.valid && cfg.ready) begin
				wheel_size_q <= cfg.data;
			end
			if (cur_load) begin
				cur_q <= div_rem[CELL_W-1:0];
			end
			if (req_acc) begin
				op_add_q <= req.kind;
			end
			if (cell_load) begin
				slot_q <= '0;
			end else if (slot_adv) begin
				slot_q <= slot_nx;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			handle_q <= req.task_id;
		end
		if (rot_load) begin
			rot_q <= div_quot[DELAY_BITS-1:0];
		end
		if (cell_load) begin
			cell_q <= div_rem[CELL_W-1:0];
		end
		if (pend_load) begin
			pend_status_q <= pend_status_nx;
			pend_handle_q <= pend_handle_nx;
		end
		if (out_push) begin
			out_status_q <= pend_status_q;
			out_handle_q <= pend_handle_q;
			out_cell_q   <= CELL_OUT_W'(cell_q);
			out_last_q   <= out_last_nx;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.task_handle = out_handle_q;
	assign rsp.cell_index  = out_cell_q;
	assign rsp.last        = out_last_q;

endmodule

>>> rtl/core/hwt_chk.sv
// hwt_chk: port-level checker for the hashed timing wheel, bound to the top level
// depends on hwt_pkg and hashed_timing_wheel

module hwt_chk import hwt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input status_t               rsp_status,
	input logic [HANDLE_W-1:0]   rsp_handle,
	input logic [CELL_OUT_W-1:0] rsp_cell,
	input logic                  rsp_last
);

	// add answers are always a single word
	a_add_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STAT_ACCEPTED || rsp_status == STAT_REJECTED) |-> rsp_last)
		else $error("add answer without last");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// clearing pass keeps requests out
	a_clear: assert property (@(posedge clk)
		!arst_n |=> !req_ready)
		else $error("ready during clearing pass");

	// stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_handle) && $stable(rsp_cell) && $stable(rsp_last))
		else $error("response word changed under stall");

endmodule

bind hashed_timing_wheel hwt_chk u_hwt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_handle (rsp.task_handle),
	.rsp_cell   (rsp.cell_index),
	.rsp_last   (rsp.last)
);

>>> dv/hwt_checker.sv
`timescale 1ns / 1ps
// hwt_checker: watches the request, response and configuration channels of the wheel,
// predicts every response word and compares it field by field; depends on hwt_pkg

module hwt_checker import hwt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_ready,
	input  logic                      req_kind,
	input  logic [DELAY_BITS_DEF-1:0] req_delay,
	input  logic [HANDLE_W-1:0]       req_task_id,
	input  logic                      rsp_valid,
	input  logic                      rsp_ready,
	input  status_t                   rsp_status,
	input  logic [HANDLE_W-1:0]       rsp_task_handle,
	input  logic [CELL_OUT_W-1:0]     rsp_cell_index,
	input  logic                      rsp_last,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data,
	output int unsigned               fail_count,
	output int unsigned               pending,
	output int unsigned               expired_seen,
	output int unsigned               rejected_seen
);

	localparam int unsigned CELLS = WHEEL_CELLS_DEF;
	localparam int unsigned SLOTS = SLOTS_PER_CELL_DEF;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   handle;
		logic [CELL_OUT_W-1:0] cell_idx;
		logic                  last;
	} outcome_t;

	logic [CFG_W-1:0]          size_reg;
	int unsigned               cur_cell;
	bit                        occupied [CELLS*SLOTS];
	logic [DELAY_BITS_DEF-1:0] laps_left [CELLS*SLOTS];
	logic [HANDLE_W-1:0]       owner [CELLS*SLOTS];
	outcome_t                  outcomes_due [$];

	function automatic int unsigned cells_in_use();
		if (size_reg == 0)
			return 1;
		if (size_reg > CELLS)
			return CELLS;
		return 32'(size_reg);
	endfunction

	function automatic void queue_word(input outcome_t w);
		outcomes_due = {outcomes_due, w};
	endfunction

	function automatic void flag(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR %0t: %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		outcome_t        want;
		outcome_t        held;
		int unsigned     cells;
		int unsigned     target;
		int unsigned     base;
		int unsigned     fired;
		bit              placed;
		longint unsigned eff;
		if (!arst_n) begin
			size_reg = WHEEL_SIZE_RST;
			cur_cell = 0;
			for (int i = 0; i < CELLS*SLOTS; i++)
				occupied[i] = 1'b0;
			outcomes_due.delete();
			fail_count = 0;
			expired_seen = 0;
			rejected_seen = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_status == STAT_EXPIRED)
					expired_seen++;
				if (rsp_status == STAT_REJECTED)
					rejected_seen++;
				if (outcomes_due.size() == 0) begin
					flag($sformatf("unexpected word: status=%0d handle=%h cell=%0d last=%b",
						rsp_status, rsp_task_handle, rsp_cell_index, rsp_last));
				end else begin
					want = outcomes_due.pop_front();
					if (rsp_status !== want.status || rsp_task_handle !== want.handle ||
						rsp_cell_index !== want.cell_idx || rsp_last !== want.last) begin
						flag($sformatf({"expected status=%0d handle=%h cell=%0d last=%b, ",
							"got status=%0d handle=%h cell=%0d last=%b"},
							want.status, want.handle, want.cell_idx, want.last,
							rsp_status, rsp_task_handle, rsp_cell_index, rsp_last));
					end
				end
			end
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			if (req_valid && req_ready) begin
				cells = cells_in_use();
				if (req_kind) begin
					eff = (req_delay == 0) ? 1 : req_delay;
					target = int'((cur_cell + eff) % cells);
					base = target * SLOTS;
					placed = 1'b0;
					for (int s = 0; s < SLOTS; s++) begin
						if (!placed && !occupied[base+s]) begin
							occupied[base+s] = 1'b1;
							laps_left[base+s] = DELAY_BITS_DEF'((eff - 1) / cells);
							owner[base+s] = req_task_id;
							placed = 1'b1;
						end
					end
					want.status = placed ? STAT_ACCEPTED : STAT_REJECTED;
					want.handle = req_task_id;
					want.cell_idx = target[CELL_OUT_W-1:0];
					want.last = 1'b1;
					queue_word(want);
				end else begin
					cur_cell = (cur_cell + 1) % cells;
					base = cur_cell * SLOTS;
					fired = 0;
					for (int s = 0; s < SLOTS; s++) begin
						if (occupied[base+s]) begin
							if (laps_left[base+s] != 0) begin
								laps_left[base+s]--;
							end else begin
								occupied[base+s] = 1'b0;
								if (fired > 0)
									queue_word(held);
								held.status = STAT_EXPIRED;
								held.handle = owner[base+s];
								held.cell_idx = cur_cell[CELL_OUT_W-1:0];
								held.last = 1'b0;
								fired++;
							end
						end
					end
					if (fired > 0) begin
						held.last = 1'b1;
						queue_word(held);
					end
				end
			end
		end
		pending = outcomes_due.size();
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives add and tick words into the hashed timing wheel over a series of
// wheel sizes with random gaps and stalls; depends on hwt_pkg, hwt_ifs, hwt_checker, hashed_timing_wheel

module testbench;
	import hwt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SETTLE      = 120;
	localparam int unsigned PER_PHASE   = 48;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          calm;
	int unsigned cycles;
	int unsigned adds_sent;
	int unsigned ticks_sent;
	int unsigned sizes_used;
	int unsigned stall_left;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned expired_seen;
	int unsigned rejected_seen;
	logic [DELAY_BITS_DEF-1:0] prev_delay;

	hwt_req_if req ();
	hwt_rsp_if rsp ();
	hwt_cfg_if cfg ();

	hashed_timing_wheel dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	hwt_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req.valid),
		.req_ready       (req.ready),
		.req_kind        (req.kind),
		.req_delay       (req.delay),
		.req_task_id     (req.task_id),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_status      (rsp.status),
		.rsp_task_handle (rsp.task_handle),
		.rsp_cell_index  (rsp.cell_index),
		.rsp_last        (rsp.last),
		.cfg_valid       (cfg.valid),
		.cfg_ready       (cfg.ready),
		.cfg_data        (cfg.data),
		.fail_count      (fail_count),
		.pending         (pending),
		.expired_seen    (expired_seen),
		.rejected_seen   (rejected_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// response side stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic send_word(input logic k, input logic [DELAY_BITS_DEF-1:0] d,
		input logic [HANDLE_W-1:0] id);
		int unsigned g;
		g = pick_gap();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.delay <= d;
		req.task_id <= id;
		do @(posedge clk); while (req.ready !== 1'b1);
		if (k)
			adds_sent++;
		else
			ticks_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		sizes_used++;
	endtask

	task automatic random_word(input int unsigned cells);
		int unsigned r;
		logic [DELAY_BITS_DEF-1:0] d;
		if ($urandom_range(0, 99) < 50) begin
			send_word(1'b0, DELAY_BITS_DEF'($urandom()), HANDLE_W'($urandom()));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 15)
				d = prev_delay;
			else if (r < 75)
				d = DELAY_BITS_DEF'($urandom_range(0, 3 * cells));
			else if (r < 90)
				d = DELAY_BITS_DEF'($urandom_range(0, 255));
			else
				d = DELAY_BITS_DEF'($urandom());
			prev_delay = d;
			send_word(1'b1, d, HANDLE_W'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] sizes [10];
		int unsigned      cells;
		sizes = '{7'd1, 7'd0, 7'd8, 7'd127, 7'd5, 7'd64, 7'd2, 7'd33, 7'd1, 7'd1};
		sizes[8] = CFG_W'($urandom_range(1, 64));
		sizes[9] = CFG_W'($urandom_range(0, 127));
		prev_delay = '0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= 1'b0;
		req.delay <= '0;
		req.task_id <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset size of 64: zero, unit, exact multiple and maximum delay, then fill one cell past full, then send ticks
		calm = 1'b0;
		send_word(1'b1, 24'd0, 16'h0000);
		send_word(1'b1, 24'd1, 16'hffff);
		send_word(1'b1, 24'd64, 16'h1234);
		send_word(1'b1, 24'd65, 16'h5a5a);
		send_word(1'b1, 24'hffffff, 16'ha5a5);
		send_word(1'b1, 24'd63, 16'h0063);
		for (int i = 0; i < 9; i++)
			send_word(1'b1, 24'd128, HANDLE_W'(16'h0100 + i));
		repeat (8) send_word(1'b0, 24'd0, 16'h0000);

		for (int p = 0; p < 10; p++) begin
			write_size(sizes[p]);
			cells = (sizes[p] == '0) ? 1 : ((sizes[p] > 7'd64) ? 64 : 32'(sizes[p]));
			calm = (p % 3 == 2);
			repeat (PER_PHASE) random_word(cells);
		end
		calm = 1'b0;
		drain();

		$display("%0d adds and %0d ticks across %0d wheel size settings", adds_sent,
			ticks_sent, sizes_used);
		$display("%0d tasks expired, %0d adds rejected on full cells, %0d mismatches",
			expired_seen, rejected_seen, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
